FILE: design/qefi_pkg.sv
package qefi_pkg;

	localparam int FRAC_BITS = 16;

	// free-space impedance rounded to q16.16
	localparam logic [24:0] Z0_FIX = 25'd24689398;

	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_BETA  = 2'd1;
	localparam logic [1:0] REG_K0    = 2'd2;
	localparam logic [1:0] REG_COUNT = 2'd3;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic MODE_TM = 1'b0;
	localparam logic MODE_TE = 1'b1;

	function automatic logic [31:0] sat32(input logic signed [47:0] v);
		logic [31:0] r;
		if (v > 48'sh0000_7FFF_FFFF) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -48'sh0000_8000_0000) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

FILE: design/quadratic_element_field_interpolator.sv
// quadratic element field interpolator
//
// slave stream: s_tuser selects the transaction kind (load or query). a load writes
// one element entry and finishes in the cycle it is accepted; it produces no result.
// a query scans the loaded entries in index order for the first one with
// left <= point < right, then evaluates the quadratic shape functions, the
// derivative and the te/tm scaling on one shared multiplier and one shared
// radix-2 divider.
// master stream: one result transaction per query; m_tuser is the found flag.
// a query reads one entry per cycle during the scan; for a hit it then runs six
// divisions and ten multiplies (twelve in tm mode) in sequence; a query that
// finds nothing ends right after the scan.
// s_tready is high only while the sequencer is idle, so one query is in flight.
// the result is held in output registers until m_tready takes it; the block
// waits meanwhile. reset returns the sequencer to idle and the registers to
// their defaults (te mode, beta 0, k0 1.0, no elements); the element tables are
// not cleared and must be loaded before use.
// configuration goes through the apb port; the user must write it only while the block is idle (not enforced).
module quadratic_element_field_interpolator #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// element_index, left_coord, right_coord, value_left, value_right, value_mid,
	// permittivity, query_point, zero pad
	input  logic [239:0] s_tdata,
	// operation
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// hit_element, primary_field, transverse_field, longitudinal_field, zero pad
	output logic [111:0] m_tdata,
	// found
	output logic         m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int KW = $clog2(MAX_ELEMENTS + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_CALC = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	localparam logic signed [19:0] ONE = 20'sd65536;

	// configuration
	logic               mode_q;
	logic signed [31:0] beta_q;
	logic [30:0]        k0_q;
	logic [10:0]        count_q;

	// control
	logic [2:0]    state_q;
	logic [4:0]    step_q;
	logic [KW-1:0] n_q;
	logic [KW-1:0] scan_k_q;
	logic [AW-1:0] chk_k_q;
	logic          chk_vld_q;
	logic [AW-1:0] hit_k_q;
	logic [5:0]    div_cnt_q;

	// element tables
	logic [31:0] left_mem  [MAX_ELEMENTS];
	logic [31:0] right_mem [MAX_ELEMENTS];
	logic [31:0] vl_mem    [MAX_ELEMENTS];
	logic [31:0] vr_mem    [MAX_ELEMENTS];
	logic [31:0] vm_mem    [MAX_ELEMENTS];
	logic [30:0] eps_mem   [MAX_ELEMENTS];

	logic signed [31:0] rd_left_q, rd_right_q, rd_vl_q, rd_vr_q, rd_vm_q;
	logic [30:0]        rd_eps_q;

	// datapath
	logic signed [31:0] x_q;
	logic signed [17:0] l1_q;
	logic signed [19:0] n0_q, n1_q, n2_q;
	logic signed [53:0] acc_q;
	logic signed [39:0] d_q;
	logic signed [47:0] p_q;
	logic signed [47:0] t_q;
	logic signed [31:0] phi_q, dphi_q, ty_q, tz_q;

	logic signed [33:0] mul_a_q, mul_b_q;
	logic signed [67:0] prod_q;

	logic        div_neg_q, div_nz_q, div_den0_q, div_l47_q;
	logic [63:0] div_num_q, div_quo_q;
	logic [31:0] div_den_q, div_rem_q;

	logic         out_found_q;
	logic [111:0] out_data_q;

	// handshake
	logic s_acc, is_load, is_query, load_ok, cfg_wr;
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign is_load  = s_acc && (s_tuser == qefi_pkg::OP_LOAD);
	assign is_query = s_acc && (s_tuser == qefi_pkg::OP_QUERY);
	assign load_ok  = 32'(s_tdata[9:0]) < 32'(MAX_ELEMENTS);
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_found_q;

	always_comb begin
		unique case (paddr[3:2])
			qefi_pkg::REG_MODE:  prdata = {31'd0, mode_q};
			qefi_pkg::REG_BETA:  prdata = beta_q;
			qefi_pkg::REG_K0:    prdata = {1'b0, k0_q};
			qefi_pkg::REG_COUNT: prdata = {21'd0, count_q};
			default:             prdata = 32'd0;
		endcase
	end

	// scan control
	logic hit, issue, scan_hit, scan_miss;
	assign hit       = (rd_left_q <= x_q) && (x_q < rd_right_q);
	assign scan_hit  = chk_vld_q && hit;
	assign issue     = scan_k_q < n_q;
	assign scan_miss = !chk_vld_q && !issue;

	// element shape coefficients
	logic signed [19:0] l1_e, l2_e, c_n0, c_n1, c_d0, c_d1, c_d2;
	logic signed [32:0] le_w, rx_w;
	assign l1_e = 20'(l1_q);
	assign l2_e = ONE - l1_e;
	assign c_n0 = (l1_e <<< 1) - ONE;
	assign c_n1 = (l2_e <<< 1) - ONE;
	assign c_d0 = ONE - (l1_e <<< 2);
	assign c_d1 = (l2_e <<< 2) - ONE;
	assign c_d2 = l1_e - l2_e;
	assign le_w = 33'(rd_right_q) - 33'(rd_left_q);
	assign rx_w = 33'(rd_right_q) - 33'(x_q);

	// divider result
	logic signed [47:0] div_res, div_hi;
	logic               div_sat;
	assign div_hi  = div_l47_q ? 48'sh7FFF_FFFF_FFFF : 48'sh0000_7FFF_FFFF;
	assign div_sat = div_den0_q ? div_nz_q
		: (div_l47_q ? (|div_quo_q[63:47]) : (|div_quo_q[63:31]));
	always_comb begin
		if (div_den0_q && !div_nz_q) begin
			div_res = 48'sd0;
		end else if (div_sat) begin
			div_res = div_neg_q ? ~div_hi : div_hi;
		end else begin
			div_res = div_neg_q ? -$signed(div_quo_q[47:0]) : $signed(div_quo_q[47:0]);
		end
	end

	logic [32:0] rem_sh;
	logic        rem_ge;
	assign rem_sh = {div_rem_q, div_num_q[63]};
	assign rem_ge = rem_sh >= {1'b0, div_den_q};

	// clamp for the impedance multiply
	logic signed [33:0] t_clamp;
	always_comb begin
		if (t_q > 48'sh0001_0000_0000) begin
			t_clamp = 34'sh1_0000_0000;
		end else if (t_q < -48'sh0001_0000_0000) begin
			t_clamp = -34'sh1_0000_0000;
		end else begin
			t_clamp = t_q[33:0];
		end
	end

	// operation launch per step
	logic               go_div, go_mul, div_l47;
	logic signed [48:0] div_a;
	logic [31:0]        div_b;
	logic signed [33:0] mul_a, mul_b;
	logic               te;
	assign te = (mode_q == qefi_pkg::MODE_TE);

	always_comb begin
		go_div  = 1'b0;
		go_mul  = 1'b0;
		div_a   = 49'sd0;
		div_b   = 32'd0;
		div_l47 = 1'b1;
		mul_a   = 34'sd0;
		mul_b   = 34'sd0;
		unique case (step_q)
			5'd0: begin
				go_div = 1'b1; div_a = 49'(rx_w); div_b = le_w[31:0];
			end
			5'd2: begin
				go_mul = 1'b1; mul_a = 34'(l1_e); mul_b = 34'(c_n0);
			end
			5'd3: begin
				go_mul = 1'b1; mul_a = 34'(l2_e); mul_b = 34'(c_n1);
			end
			5'd4: begin
				go_mul = 1'b1; mul_a = 34'(l1_e); mul_b = 34'(l2_e);
			end
			5'd5: begin
				go_mul = 1'b1; mul_a = 34'(n0_q); mul_b = 34'(rd_vl_q);
			end
			5'd6: begin
				go_mul = 1'b1; mul_a = 34'(n1_q); mul_b = 34'(rd_vr_q);
			end
			5'd7: begin
				go_mul = 1'b1; mul_a = 34'(n2_q); mul_b = 34'(rd_vm_q);
			end
			5'd8: begin
				go_mul = 1'b1; mul_a = 34'(c_d0); mul_b = 34'(rd_vl_q);
			end
			5'd9: begin
				go_mul = 1'b1; mul_a = 34'(c_d1); mul_b = 34'(rd_vr_q);
			end
			5'd10: begin
				go_mul = 1'b1; mul_a = 34'(c_d2); mul_b = 34'(rd_vm_q);
			end
			5'd11: begin
				go_mul = 1'b1; mul_a = 34'(beta_q); mul_b = 34'(phi_q);
			end
			5'd12: begin
				go_div = 1'b1; div_a = 49'(d_q); div_b = le_w[31:0]; div_l47 = 1'b0;
			end
			5'd13: begin
				go_div = 1'b1; div_a = 49'(p_q); div_b = {1'b0, k0_q};
			end
			5'd15, 5'd20: begin
				go_div  = 1'b1;
				div_a   = 49'(t_q);
				div_b   = te ? {7'd0, qefi_pkg::Z0_FIX} : {1'b0, rd_eps_q};
				div_l47 = !te;
			end
			5'd17, 5'd22: begin
				go_mul = !te; mul_a = t_clamp; mul_b = 34'(qefi_pkg::Z0_FIX);
			end
			5'd18: begin
				go_div = 1'b1;
				div_a  = te ? -49'(dphi_q) : 49'(dphi_q);
				div_b  = {1'b0, k0_q};
			end
			default: begin
			end
		endcase
	end

	logic [48:0] div_mag;
	assign div_mag = div_a[48] ? 49'(-div_a) : 49'(div_a);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= qefi_pkg::MODE_TE;
			beta_q    <= 32'sd0;
			k0_q      <= 31'd65536;
			count_q   <= 11'd0;
			state_q   <= ST_IDLE;
			step_q    <= 5'd0;
			n_q       <= '0;
			scan_k_q  <= '0;
			chk_vld_q <= 1'b0;
			div_cnt_q <= 6'd0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[3:2])
					qefi_pkg::REG_MODE:  mode_q  <= pwdata[0];
					qefi_pkg::REG_BETA:  beta_q  <= pwdata;
					qefi_pkg::REG_K0:    k0_q    <= pwdata[30:0];
					qefi_pkg::REG_COUNT: count_q <= pwdata[10:0];
					default: begin
					end
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (is_query) begin
						state_q   <= ST_SCAN;
						scan_k_q  <= '0;
						chk_vld_q <= 1'b0;
						n_q <= ({21'd0, count_q} > 32'(MAX_ELEMENTS)) ? KW'(MAX_ELEMENTS)
							: KW'(count_q);
					end
				end
				ST_SCAN: begin
					priority if (scan_hit) begin
						state_q <= ST_CALC;
						step_q  <= 5'd0;
					end else if (scan_miss) begin
						state_q <= ST_OUT;
					end else begin
						chk_vld_q <= issue;
						if (issue) begin
							scan_k_q <= scan_k_q + 1'b1;
						end
					end
				end
				ST_CALC: begin
					step_q <= step_q + 1'b1;
					priority if (step_q == 5'd23) begin
						state_q <= ST_OUT;
					end else if (go_div) begin
						state_q   <= ST_DIV;
						div_cnt_q <= 6'd0;
					end else if (go_mul) begin
						state_q <= ST_MUL;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 6'd63) begin
						state_q <= ST_CALC;
					end
				end
				ST_MUL: begin
					state_q <= ST_CALC;
				end
				ST_OUT: begin
					if (m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// element tables
	always_ff @(posedge clk) begin
		if (is_load && load_ok) begin
			left_mem[AW'(s_tdata[9:0])]  <= s_tdata[41:10];
			right_mem[AW'(s_tdata[9:0])] <= s_tdata[73:42];
			vl_mem[AW'(s_tdata[9:0])]    <= s_tdata[105:74];
			vr_mem[AW'(s_tdata[9:0])]    <= s_tdata[137:106];
			vm_mem[AW'(s_tdata[9:0])]    <= s_tdata[169:138];
			eps_mem[AW'(s_tdata[9:0])]   <= s_tdata[200:170];
		end
		if ((state_q == ST_SCAN) && !scan_hit && issue) begin
			rd_left_q  <= left_mem[scan_k_q[AW-1:0]];
			rd_right_q <= right_mem[scan_k_q[AW-1:0]];
			rd_vl_q    <= vl_mem[scan_k_q[AW-1:0]];
			rd_vr_q    <= vr_mem[scan_k_q[AW-1:0]];
			rd_vm_q    <= vm_mem[scan_k_q[AW-1:0]];
			rd_eps_q   <= eps_mem[scan_k_q[AW-1:0]];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (is_query) begin
			x_q <= s_tdata[232:201];
		end
		if ((state_q == ST_SCAN) && !scan_hit && !scan_miss) begin
			chk_k_q <= scan_k_q[AW-1:0];
		end
		if ((state_q == ST_SCAN) && scan_hit) begin
			hit_k_q <= chk_k_q;
		end
		if ((state_q == ST_SCAN) && scan_miss) begin
			out_found_q <= 1'b0;
			out_data_q  <= 112'd0;
		end
		if (state_q == ST_MUL) begin
			prod_q <= mul_a_q * mul_b_q;
		end
		if (state_q == ST_DIV) begin
			div_num_q <= {div_num_q[62:0], 1'b0};
			div_quo_q <= {div_quo_q[62:0], rem_ge};
			div_rem_q <= rem_ge ? 32'(rem_sh - {1'b0, div_den_q}) : rem_sh[31:0];
		end
		if (state_q == ST_CALC) begin
			if (go_div) begin
				div_neg_q  <= div_a[48];
				div_nz_q   <= div_mag != 49'd0;
				div_num_q  <= {div_mag[47:0], 16'd0};
				div_den_q  <= div_b;
				div_den0_q <= div_b == 32'd0;
				div_l47_q  <= div_l47;
				div_rem_q  <= 32'd0;
				div_quo_q  <= 64'd0;
			end
			if (go_mul) begin
				mul_a_q <= mul_a;
				mul_b_q <= mul_b;
			end
			unique case (step_q)
				5'd1:  l1_q  <= div_res[17:0];
				5'd3:  n0_q  <= prod_q[35:16];
				5'd4:  n1_q  <= prod_q[35:16];
				5'd5:  n2_q  <= prod_q[33:14];
				5'd6:  acc_q <= prod_q[53:0];
				5'd7:  acc_q <= acc_q + prod_q[53:0];
				5'd8:  acc_q <= acc_q + prod_q[53:0];
				5'd9: begin
					phi_q <= qefi_pkg::sat32(48'($signed(acc_q[53:16])));
					d_q   <= prod_q[55:16];
				end
				5'd10: d_q    <= d_q + prod_q[55:16];
				5'd11: d_q    <= d_q + prod_q[53:14];
				5'd12: p_q    <= prod_q[63:16];
				5'd13: dphi_q <= div_res[31:0];
				5'd14: t_q    <= div_res;
				5'd16: begin
					if (te) begin
						ty_q <= div_res[31:0];
					end else begin
						t_q <= div_res;
					end
				end
				5'd18: begin
					if (!te) begin
						ty_q <= qefi_pkg::sat32(-48'($signed(prod_q[59:16])));
					end
				end
				5'd19: t_q <= div_res;
				5'd21: begin
					if (te) begin
						tz_q <= div_res[31:0];
					end else begin
						t_q <= div_res;
					end
				end
				5'd23: begin
					out_found_q <= 1'b1;
					out_data_q  <= {6'd0,
						(te ? tz_q : qefi_pkg::sat32(48'($signed(prod_q[59:16])))),
						ty_q, phi_q, 10'(hit_k_q)};
				end
				default: begin
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n) !(s_tready && m_tvalid))
		else $error("input ready while a result is pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == 112'd0))
		else $error("miss result carries nonzero fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser) |=> !s_tready)
		else $error("query accepted but sequencer stayed idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (step_q == 5'd1 || step_q == 5'd13 || step_q == 5'd14
			|| step_q == 5'd16 || step_q == 5'd19 || step_q == 5'd21))
		else $error("divider running at a step with no quotient consumer");
`endif

endmodule
